>>> src/lpfs_pkg.sv
// Shared types and constants for the length-prefixed frame splitter.
// Used by every module of the block; depends on nothing.
package lpfs_pkg;

   localparam int LENGTH_BYTES_DEFAULT = 4;
   localparam int CFG_W = 32;
   localparam logic [CFG_W-1:0] MAX_FRAME_BYTES_RESET = 32'd16777216;

   localparam int PHASE_W = 2;
   localparam logic [PHASE_W-1:0] PHASE_HEADER  = 2'd0;
   localparam logic [PHASE_W-1:0] PHASE_PAYLOAD = 2'd1;
   localparam logic [PHASE_W-1:0] PHASE_HALTED  = 2'd2;

   typedef struct packed {
      logic [7:0] payload_byte;
      logic       last_of_frame;
      logic       empty_frame;
      logic       oversize_error;
   } result_type;

   typedef struct packed {
      logic halted;
   } status_type;

endpackage

>>> src/lpfs_csr.sv
// Configuration register holding the largest accepted payload length.
// Depends on lpfs_pkg.
module lpfs_csr (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [lpfs_pkg::CFG_W-1:0] csr_data,
   output logic [lpfs_pkg::CFG_W-1:0] max_frame_bytes
);
   import lpfs_pkg::*;

   logic [CFG_W-1:0] max_ff;
   logic [CFG_W-1:0] max_in;

   assign csr_ready = 1'b1;
   assign max_in = (csr_valid && csr_ready) ? csr_data : max_ff;
   assign max_frame_bytes = max_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff <= MAX_FRAME_BYTES_RESET;
      end else begin
         max_ff <= max_in;
      end
   end

endmodule

>>> src/lpfs_parse.sv
// Frame parser: gathers the length header, counts payload bytes and forms
// at most one result per transaction. Depends on lpfs_pkg.
module lpfs_parse #(
   parameter int LENGTH_BYTES = lpfs_pkg::LENGTH_BYTES_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       item_take,
   input  logic [7:0]                 data_byte,
   input  logic [lpfs_pkg::CFG_W-1:0] max_frame_bytes,
   output logic                       result_valid,
   output lpfs_pkg::result_type       result,
   output lpfs_pkg::status_type       status
);
   import lpfs_pkg::*;

   localparam int HDR_W = 8 * LENGTH_BYTES;
   localparam int CNT_W = (LENGTH_BYTES > 1) ? $clog2(LENGTH_BYTES) : 1;
   localparam int CMP_W = (HDR_W > CFG_W) ? HDR_W : CFG_W;

   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [HDR_W-1:0]   header_ff, header_in;
   logic [CFG_W-1:0]   remain_ff, remain_in;

   logic [HDR_W-1:0] hdr_len;
   logic [CMP_W-1:0] len_wide;
   logic [CMP_W-1:0] max_wide;
   logic [CFG_W-1:0] remain_dec;
   logic             hdr_done;
   logic             oversize;

   assign hdr_len    = HDR_W'({header_ff, data_byte});
   assign len_wide   = CMP_W'(hdr_len);
   assign max_wide   = CMP_W'(max_frame_bytes);
   assign oversize   = len_wide > max_wide;
   assign hdr_done   = count_ff == CNT_W'(LENGTH_BYTES - 1);
   assign remain_dec = remain_ff - CFG_W'(1);

   always_comb begin
      phase_in     = phase_ff;
      count_in     = count_ff;
      header_in    = header_ff;
      remain_in    = remain_ff;
      result_valid = 1'b0;
      result       = '0;
      unique case (phase_ff)
         PHASE_HEADER: begin
            if (hdr_done) begin
               count_in  = '0;
               header_in = '0;
               if (oversize) begin
                  phase_in              = PHASE_HALTED;
                  result_valid          = 1'b1;
                  result.oversize_error = 1'b1;
               end else if (len_wide == '0) begin
                  result_valid         = 1'b1;
                  result.last_of_frame = 1'b1;
                  result.empty_frame   = 1'b1;
               end else begin
                  remain_in = len_wide[CFG_W-1:0];
                  phase_in  = PHASE_PAYLOAD;
               end
            end else begin
               count_in  = CNT_W'(count_ff + CNT_W'(1));
               header_in = hdr_len;
            end
         end
         PHASE_PAYLOAD: begin
            remain_in           = remain_dec;
            result_valid        = 1'b1;
            result.payload_byte = data_byte;
            if (remain_dec == '0) begin
               result.last_of_frame = 1'b1;
               phase_in             = PHASE_HEADER;
            end
         end
         PHASE_HALTED: begin
            phase_in = PHASE_HALTED;
         end
         default: begin
            phase_in = PHASE_HALTED;
         end
      endcase
   end

   assign status.halted = phase_ff == PHASE_HALTED;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PHASE_HEADER;
         count_ff  <= '0;
         header_ff <= '0;
         remain_ff <= '0;
      end else if (item_take) begin
         phase_ff  <= phase_in;
         count_ff  <= count_in;
         header_ff <= header_in;
         remain_ff <= remain_in;
      end
   end

endmodule

>>> src/lpfs_rsp_reg.sv
// Result register of the splitter: holds one result until the downstream
// side takes it, and accepts a new one in the same cycle. Depends on lpfs_pkg.
module lpfs_rsp_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 item_take,
   input  logic                 result_valid,
   input  lpfs_pkg::result_type result,
   output logic                 take_ready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output lpfs_pkg::result_type rsp_result
);
   import lpfs_pkg::*;

   logic       valid_ff, valid_in;
   result_type data_ff, data_in;

   assign take_ready = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (item_take && result_valid) begin
         valid_in = 1'b1;
         data_in  = result;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_result = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule

>>> src/length_prefix_frame_splitter.sv
// Splits a byte stream into frames that each start with a big-endian length
// header of LENGTH_BYTES bytes. One byte is taken per transaction, every
// cycle while the result side keeps up; a result appears in the cycle after its
// byte is taken, held in the single result register. An oversize header gives
// one error result and the block then drops every byte until reset.
// Depends on lpfs_pkg, lpfs_csr, lpfs_parse and lpfs_rsp_reg.
module length_prefix_frame_splitter #(
   parameter int LENGTH_BYTES = lpfs_pkg::LENGTH_BYTES_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [7:0]                 req_tdata,   // data_byte[7:0]
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [7:0]                 rsp_tdata,   // payload_byte[7:0]
   output logic                       rsp_tlast,
   output logic [1:0]                 rsp_tuser,   // oversize_error, empty_frame
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [lpfs_pkg::CFG_W-1:0] csr_data
);
   import lpfs_pkg::*;

   logic [CFG_W-1:0] max_frame_bytes;
   logic             item_take;
   logic             result_valid;
   result_type       result;
   result_type       rsp_result;
   status_type       status;

   assign item_take = req_tvalid && req_tready;

   lpfs_csr u_csr (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_data        (csr_data),
      .max_frame_bytes (max_frame_bytes)
   );

   lpfs_parse #(
      .LENGTH_BYTES (LENGTH_BYTES)
   ) u_parse (
      .clock           (clock),
      .reset           (reset),
      .item_take       (item_take),
      .data_byte       (req_tdata),
      .max_frame_bytes (max_frame_bytes),
      .result_valid    (result_valid),
      .result          (result),
      .status          (status)
   );

   lpfs_rsp_reg u_rsp_reg (
      .clock        (clock),
      .reset        (reset),
      .item_take    (item_take),
      .result_valid (result_valid),
      .result       (result),
      .take_ready   (req_tready),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_result   (rsp_result)
   );

   assign rsp_tdata = rsp_result.payload_byte;
   assign rsp_tlast = rsp_result.last_of_frame;
   assign rsp_tuser = {rsp_result.oversize_error, rsp_result.empty_frame};

   a_halt_sticky : assert property (@(posedge clock) disable iff (reset)
      status.halted |=> status.halted)
      else $error("halted state left without reset");

   a_error_halts : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> status.halted && !rsp_tlast)
      else $error("error result without halted state");

   a_empty_form : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tlast && rsp_tdata == 8'd0 && !rsp_tuser[1])
      else $error("malformed empty-frame result");

   a_ready_when_free : assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with free result register");

endmodule

>>> dv/length_prefix_frame_splitter_tb.sv
// Self-checking testbench for length_prefix_frame_splitter: drives framed byte
// streams under several frame size limits and checks every result transaction.
// Depends on lpfs_pkg and the length_prefix_frame_splitter RTL.
`timescale 1ns / 100ps

module length_prefix_frame_splitter_tb;
   import lpfs_pkg::*;

   localparam int HDR_BYTES = LENGTH_BYTES_DEFAULT;
   localparam int CYCLE_LIMIT = 200000;

   class frame_split_board;
      logic [CFG_W-1:0]   limit;
      logic [PHASE_W-1:0] phase;
      int unsigned        hdr_count;
      logic [63:0]        hdr_value;
      logic [31:0]        remaining;
      result_type         expected_results[$];
      int                 errors;

      function new();
         limit = MAX_FRAME_BYTES_RESET;
         phase = PHASE_HEADER;
         hdr_count = 0;
         hdr_value = '0;
         remaining = '0;
         errors = 0;
      endfunction

      function void set_limit(logic [CFG_W-1:0] value);
         limit = value;
      endfunction

      function int pending();
         return expected_results.size();
      endfunction

      function void push_result(logic [7:0] data, logic last, logic empty, logic oversize);
         result_type r;
         r.payload_byte = data;
         r.last_of_frame = last;
         r.empty_frame = empty;
         r.oversize_error = oversize;
         expected_results = {expected_results, r};
      endfunction

      function void take_byte(logic [7:0] b);
         if (phase == PHASE_HEADER) begin
            hdr_value = {hdr_value[55:0], b};
            hdr_count++;
            if (hdr_count == HDR_BYTES) begin
               hdr_count = 0;
               if (hdr_value > {32'd0, limit}) begin
                  phase = PHASE_HALTED;
                  push_result(8'd0, 1'b0, 1'b0, 1'b1);
               end else if (hdr_value == 64'd0) begin
                  push_result(8'd0, 1'b1, 1'b1, 1'b0);
               end else begin
                  remaining = hdr_value[31:0];
                  phase = PHASE_PAYLOAD;
               end
               hdr_value = '0;
            end
         end else if (phase == PHASE_PAYLOAD) begin
            remaining = remaining - 32'd1;
            if (remaining == 32'd0) begin
               phase = PHASE_HEADER;
               push_result(b, 1'b1, 1'b0, 1'b0);
            end else begin
               push_result(b, 1'b0, 1'b0, 1'b0);
            end
         end
      endfunction

      function void note_error(string msg);
         errors++;
         if (errors <= 10) $display("ERROR at %0t: %s", $time, msg);
      endfunction

      function void check_result(result_type got);
         result_type exp;
         if (expected_results.size() == 0) begin
            note_error($sformatf("unexpected result byte=%0h last=%0b empty=%0b oversize=%0b",
               got.payload_byte, got.last_of_frame, got.empty_frame, got.oversize_error));
            return;
         end
         exp = expected_results.pop_front();
         if (got.payload_byte !== exp.payload_byte || got.last_of_frame !== exp.last_of_frame ||
             got.empty_frame !== exp.empty_frame || got.oversize_error !== exp.oversize_error)
            note_error($sformatf({"mismatch: expected byte=%0h last=%0b empty=%0b oversize=%0b,",
               " got byte=%0h last=%0b empty=%0b oversize=%0b"},
               exp.payload_byte, exp.last_of_frame, exp.empty_frame, exp.oversize_error,
               got.payload_byte, got.last_of_frame, got.empty_frame, got.oversize_error));
      endfunction

      function void check_leftover();
         while (expected_results.size() != 0) begin
            void'(expected_results.pop_front());
            note_error("expected result never arrived");
         end
      endfunction
   endclass

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [7:0]       req_tdata = 8'd0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [7:0]       rsp_tdata;
   logic             rsp_tlast;
   logic [1:0]       rsp_tuser;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [CFG_W-1:0] csr_data = '0;

   frame_split_board board;
   bit               idle_on = 1'b0;
   int               stall_left = 0;
   int               cycles = 0;
   result_type       seen;

   length_prefix_frame_splitter #(
      .LENGTH_BYTES(HDR_BYTES)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("length_prefix_frame_splitter test failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
         stall_left <= $urandom_range(0, 11);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // The check runs just after the edge so that a byte accepted at the same
   // edge has already been noted.
   always begin
      @(posedge clock);
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         seen.payload_byte = rsp_tdata;
         seen.last_of_frame = rsp_tlast;
         seen.empty_frame = rsp_tuser[0];
         seen.oversize_error = rsp_tuser[1];
         #1 board.check_result(seen);
      end
   end

   task automatic send_byte(input logic [7:0] b);
      if (idle_on && $urandom_range(0, 7) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.take_byte(b);
   endtask

   task automatic send_header(input logic [63:0] len);
      for (int i = HDR_BYTES - 1; i >= 0; i--) send_byte(len[8*i +: 8]);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_limit(input logic [CFG_W-1:0] value);
      csr_valid <= 1'b1;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      board.set_limit(value);
      csr_valid <= 1'b0;
   endtask

   function automatic int unsigned pick_length(logic [CFG_W-1:0] lim);
      int unsigned cap;
      int unsigned top;
      int unsigned pick;
      cap = ($urandom_range(0, 19) == 0) ? 300 : 24;
      top = (lim < cap) ? lim : cap;
      pick = $urandom_range(0, 9);
      if (top == 0 || pick == 0) return 0;
      if (pick == 1) return top;
      return $urandom_range(1, top);
   endfunction

   initial begin
      logic [CFG_W-1:0] limits[7];
      int unsigned      len;
      int unsigned      sent;
      board = new();
      limits = '{MAX_FRAME_BYTES_RESET, 32'd0, 32'd1, 32'd7, 32'd300, 32'hFFFF_FFFF, 32'd40};
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      idle_on = 1'b1;

      send_header(64'd0);
      send_header(64'd1);
      send_byte(8'hFF);
      send_header(64'd3);
      send_byte(8'h00);
      send_byte(8'hA5);
      send_byte(8'h5A);
      // A limit written mid-frame must leave the frame in progress alone.
      send_header(64'd4);
      send_byte(8'h80);
      send_byte(8'h7F);
      wait_drained();
      write_limit(32'd1);
      send_byte(8'h01);
      send_byte(8'hFE);
      send_header(64'd1);
      send_byte(8'h55);

      for (int p = 0; p < 7; p++) begin
         wait_drained();
         write_limit(limits[p]);
         idle_on = (p < 5) && (p != 2);
         sent = 0;
         while (sent < 115) begin
            len = pick_length(limits[p]);
            send_header(64'(len));
            for (int unsigned i = 0; i < len; i++) send_byte(8'($urandom_range(0, 255)));
            sent += HDR_BYTES + len;
            if ($urandom_range(0, 49) == 0) wait_drained();
         end
      end

      // An oversize header halts the block for the rest of the run.
      wait_drained();
      write_limit(32'hFFFF_FFFE);
      send_header(64'hFFFF_FFFF);
      repeat (8) send_byte(8'($urandom_range(0, 255)));
      wait_drained();
      repeat (10) @(posedge clock);
      board.check_leftover();
      if (board.errors == 0) begin
         $display("length_prefix_frame_splitter test passed");
      end else begin
         $display("length_prefix_frame_splitter test failed");
      end
      $finish;
   end

endmodule

>>> filelist.f
src/lpfs_pkg.sv
src/lpfs_csr.sv
src/lpfs_parse.sv
src/lpfs_rsp_reg.sv
src/length_prefix_frame_splitter.sv
dv/length_prefix_frame_splitter_tb.sv
